FILE: rtl/core/kvl_pkg.sv
package kvl_pkg;

    // Default sizes
    localparam int KEY_MAX_DEF  = 16;
    localparam int LINE_MAX_DEF = 1024;

    // Keyword register geometry: two 64-bit words, eight characters each
    localparam int CFG_DATA_W   = 64;
    localparam int KEY_BYTES    = 16;
    localparam int KEY_LEN_W    = 5;

    // Register indexes
    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index REG_KEY_LOW  = 2'd0;
    localparam t_cfg_index REG_KEY_HIGH = 2'd1;
    localparam t_cfg_index REG_KEY_LEN  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] CH_TAB      = 8'd9;
    localparam logic [7:0] CH_EQUAL    = 8'd61;
    localparam logic [7:0] CH_LOWER_A  = 8'd97;
    localparam logic [7:0] CH_LOWER_Z  = 8'd122;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    // Per-line search phase
    typedef enum logic [3:0] {
        PH_SEARCH    = 4'b0001,
        PH_AFTER_KEY = 4'b0010,
        PH_FOUND     = 4'b0100,
        PH_FAILED    = 4'b1000
    } t_phase;

    // Control handed to one window cell
    typedef struct packed {
        logic [7:0] key_ch;  // keyword character aligned to this cell
        logic       active;  // cell lies inside the keyword span
        logic       guard;   // cell holds the character before the span
    } t_cell_ctl;

    // Status returned by one window cell
    typedef struct packed {
        logic hit;           // character agrees, or cell not in the span
        logic guard_blank;   // guard cell sees a space or tab
    } t_cell_stat;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

endpackage

FILE: rtl/core/keyword_value_locator.sv
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+----------------------------------
// input    | in        | i_in_valid / o_in_stall | i_ch, i_last
// output   | out       | o_out_valid/ i_out_stall| o_found, o_keyword_pos,
//          |           |                         | o_value_pos, o_too_long
// config   | in        | i_cfg_we                | i_cfg_index, i_cfg_data
//
// One character per cycle unless stalled; the window compare runs across a chain of
// KEY_MAX+1 cells in the same cycle the character shifts in.
// A result word is registered on the cycle the last character is taken and is shown
// the next cycle; the input stalls only while that word waits under output stall.
// Reset (synchronous, active low) clears the line state, the keyword and sets length 1.
module keyword_value_locator #(
    parameter int KEY_MAX  = kvl_pkg::KEY_MAX_DEF,
    parameter int LINE_MAX = kvl_pkg::LINE_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_ch,
    input  logic                          i_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [9:0]                    o_keyword_pos,
    output logic [10:0]                   o_value_pos,
    output logic                          o_too_long,
    input  logic                          i_cfg_we,
    input  kvl_pkg::t_cfg_index           i_cfg_index,
    input  logic [kvl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PW     = $clog2(LINE_MAX + 1);
    localparam int CW     = PW + 6;
    localparam int NCELLS = KEY_MAX + 1;
    localparam int LW     = kvl_pkg::KEY_LEN_W;

    // Configuration
    logic [kvl_pkg::CFG_DATA_W-1:0] r_key_low;
    logic [kvl_pkg::CFG_DATA_W-1:0] r_key_high;
    logic [LW-1:0]                  r_key_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_key_len  <= LW'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kvl_pkg::REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                kvl_pkg::REG_KEY_HIGH: r_key_high <= i_cfg_data;
                kvl_pkg::REG_KEY_LEN:  r_key_len  <= i_cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the keyword length to 1..KEY_MAX
    logic [LW-1:0] len;
    always_comb begin
        if (r_key_len == '0) begin
            len = LW'(1);
        end else if (r_key_len > LW'(KEY_MAX)) begin
            len = LW'(KEY_MAX);
        end else begin
            len = r_key_len;
        end
    end

    logic [7:0] key_bytes [kvl_pkg::KEY_BYTES];
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            key_bytes[b]     = r_key_low[8*b +: 8];
            key_bytes[b + 8] = r_key_high[8*b +: 8];
        end
    end

    // Handshake
    logic r_out_valid;
    logic in_acc;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    // Line state
    kvl_pkg::t_phase r_phase, n_phase;
    logic [PW-1:0]   r_pos, n_pos;
    logic [PW-1:0]   r_match_start, n_match_start;
    logic [PW-1:0]   r_eq_pos, n_eq_pos;
    logic            r_overflow, n_overflow;

    logic pos_ok;
    assign pos_ok = r_pos < PW'(LINE_MAX);

    // Fold lowercase to uppercase
    logic [7:0] folded;
    assign folded = ((i_ch >= kvl_pkg::CH_LOWER_A) && (i_ch <= kvl_pkg::CH_LOWER_Z))
                    ? (i_ch - kvl_pkg::CASE_OFFSET) : i_ch;

    // Chain of window cells
    logic [7:0]          cell_in   [NCELLS];
    logic [7:0]          cell_out  [NCELLS];
    kvl_pkg::t_cell_ctl  cell_ctl  [NCELLS];
    kvl_pkg::t_cell_stat cell_stat [NCELLS];
    logic [NCELLS-1:0]   hit_vec;
    logic [NCELLS-1:0]   blank_vec;
    logic                shift_en;

    assign shift_en = in_acc && pos_ok;

    for (genvar j = 0; j < NCELLS; j++) begin : g_cell
        logic [LW-1:0] kidx;
        assign kidx = len - LW'(j) - LW'(1);

        if (j == 0) begin : g_head
            assign cell_in[j] = folded;
        end else begin : g_link
            assign cell_in[j] = cell_out[j-1];
        end

        assign cell_ctl[j].key_ch = key_bytes[kidx[3:0]];
        assign cell_ctl[j].active = LW'(j) < len;
        assign cell_ctl[j].guard  = LW'(j) == len;

        kvl_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (shift_en),
            .i_ch   (cell_in[j]),
            .i_ctl  (cell_ctl[j]),
            .o_ch   (cell_out[j]),
            .o_stat (cell_stat[j])
        );

        assign hit_vec[j]   = cell_stat[j].hit;
        assign blank_vec[j] = cell_stat[j].guard_blank;
    end

    // Position arithmetic
    logic [CW-1:0] pos_inc;
    logic [CW-1:0] len_ext;
    logic [CW-1:0] start_ext;
    logic          span_full;
    assign pos_inc   = {{(CW-PW){1'b0}}, r_pos} + CW'(1);
    assign len_ext   = {{(CW-LW){1'b0}}, len};
    assign start_ext = pos_inc - len_ext;
    assign span_full = pos_inc >= len_ext;

    // Advance the search
    always_comb begin
        n_phase       = r_phase;
        n_pos         = r_pos;
        n_match_start = r_match_start;
        n_eq_pos      = r_eq_pos;
        n_overflow    = r_overflow;
        if (in_acc) begin
            if (!pos_ok) begin
                n_overflow = 1'b1;
            end else begin
                n_pos = pos_inc[PW-1:0];
                unique case (r_phase)
                    kvl_pkg::PH_SEARCH: begin
                        if (span_full && (&hit_vec)) begin
                            n_match_start = start_ext[PW-1:0];
                            n_phase = ((start_ext == '0) || (|blank_vec))
                                      ? kvl_pkg::PH_AFTER_KEY : kvl_pkg::PH_FAILED;
                        end
                    end
                    kvl_pkg::PH_AFTER_KEY: begin
                        if (i_ch == kvl_pkg::CH_EQUAL) begin
                            n_eq_pos = pos_inc[PW-1:0];
                            n_phase  = kvl_pkg::PH_FOUND;
                        end else if (!kvl_pkg::is_blank(i_ch)) begin
                            n_phase = kvl_pkg::PH_FAILED;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Hold line state; drop it after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_acc && i_last)) begin
            r_phase       <= kvl_pkg::PH_SEARCH;
            r_pos         <= '0;
            r_match_start <= '0;
            r_eq_pos      <= '0;
            r_overflow    <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_pos         <= n_pos;
            r_match_start <= n_match_start;
            r_eq_pos      <= n_eq_pos;
            r_overflow    <= n_overflow;
        end
    end

    // Result word
    logic          res_found;
    logic [PW+10:0] kpos_ext;
    logic [PW+10:0] vpos_ext;
    assign res_found = n_phase == kvl_pkg::PH_FOUND;
    assign kpos_ext  = {{11{1'b0}}, (res_found ? n_match_start : PW'(0))};
    assign vpos_ext  = {{11{1'b0}}, (res_found ? n_eq_pos : PW'(0))};

    logic        r_found;
    logic [9:0]  r_keyword_pos;
    logic [10:0] r_value_pos;
    logic        r_too_long;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && i_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_last) begin
            r_found       <= res_found;
            r_keyword_pos <= kpos_ext[9:0];
            r_value_pos   <= vpos_ext[10:0];
            r_too_long    <= n_overflow;
        end
    end

    assign o_found       = r_found;
    assign o_keyword_pos = r_keyword_pos;
    assign o_value_pos   = r_value_pos;
    assign o_too_long    = r_too_long;

endmodule

FILE: rtl/core/kvl_cell.sv
module kvl_cell (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [7:0]         i_ch,
    input  kvl_pkg::t_cell_ctl i_ctl,
    output logic [7:0]         o_ch,
    output kvl_pkg::t_cell_stat o_stat
);

    logic [7:0] r_ch;

    // Shift the neighbor's character in, or the folded input character at the head
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ch <= i_ch;
        end
    end

    assign o_ch = r_ch;

    // Compare the character entering this cell against its keyword character
    assign o_stat.hit         = !i_ctl.active || (i_ch == i_ctl.key_ch);
    assign o_stat.guard_blank = i_ctl.guard && kvl_pkg::is_blank(i_ch);

endmodule
